FILE: src/bfa_pkg.sv
// Shared constants, codes and control types of the bitmap first-fit slot allocator.
package bfa_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int NODE_BYTES = 64;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 32;
  localparam int USED_W = 7;
  localparam int STATUS_W = 2;

  localparam logic [ADDR_W-1:0] POOL_BYTES = ADDR_W'(NUM_SLOTS * NODE_BYTES);

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RUN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic set_norun;
    logic fill;
    logic clear_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                kind;
    logic                scan_stop;
    logic                scan_found;
    logic                clear_stop;
    logic                out_busy;
  } dp_stat_t;

endpackage

FILE: src/bfa_in_if.sv
// Request channel interface: transaction kind, byte size and release address.
interface bfa_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [bfa_pkg::SIZE_W-1:0]     size_bytes;
  logic [bfa_pkg::ADDR_W-1:0]     address;

  modport source (output valid, kind, size_bytes, address, input ready);
  modport sink (input valid, kind, size_bytes, address, output ready);
endinterface

FILE: src/bfa_out_if.sv
// Result channel interface: status, allocated address, used count and empty flag.
interface bfa_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::STATUS_W-1:0]   status;
  logic [bfa_pkg::ADDR_W-1:0]     address_res;
  logic [bfa_pkg::USED_W-1:0]     used_slots;
  logic                           pool_empty;

  modport source (output valid, status, address_res, used_slots, pool_empty, input ready);
  modport sink (input valid, status, address_res, used_slots, pool_empty, output ready);
endinterface

FILE: src/bfa_ctrl.sv
// Controller state machine that sequences check, scan, fill, clear and result load.
module bfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfa_pkg::dp_stat_t   stat,
  output bfa_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.status != bfa_pkg::ST_OK) begin
          state_nxt = S_DONE;
        end else if (stat.kind == bfa_pkg::KIND_ALLOC) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_CLEAR;
        end
      end
      S_SCAN: begin
        if (stat.scan_stop) begin
          if (stat.scan_found) begin
            state_nxt = S_FILL;
          end else begin
            cmd.set_norun = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        if (stat.clear_stop) begin
          state_nxt = S_DONE;
        end else begin
          cmd.clear_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/bfa_dp.sv
// Datapath holding the slot bitmap, used count, scan counters and the result register.
module bfa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bfa_pkg::ADDR_W-1:0]     cfg_wdata,
  input  logic                           in_kind,
  input  logic [bfa_pkg::SIZE_W-1:0]     in_size_bytes,
  input  logic [bfa_pkg::ADDR_W-1:0]     in_address,
  input  bfa_pkg::ctrl_cmd_t             cmd,
  output bfa_pkg::dp_stat_t              stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bfa_pkg::STATUS_W-1:0]   out_status,
  output logic [bfa_pkg::ADDR_W-1:0]     out_address_res,
  output logic [bfa_pkg::USED_W-1:0]     out_used_slots,
  output logic                           out_pool_empty
);

  logic [bfa_pkg::ADDR_W-1:0]    pool_base_r, pool_base_nxt;
  logic [bfa_pkg::NUM_SLOTS-1:0] map_r, map_nxt;
  logic [bfa_pkg::CNT_W-1:0]     used_r, used_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [bfa_pkg::CNT_W-1:0]     nodes_r, nodes_nxt;
  logic [bfa_pkg::CNT_W-1:0]     slot_r, slot_nxt;
  logic [bfa_pkg::CNT_W-1:0]     run_r, run_nxt;
  logic [bfa_pkg::NUM_SLOTS-1:0] len_mask_r, len_mask_nxt;
  logic                          kind_r, kind_nxt;
  logic [bfa_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [bfa_pkg::ADDR_W-1:0]    res_addr_r, res_addr_nxt;

  logic [bfa_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [bfa_pkg::ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [bfa_pkg::USED_W-1:0]    out_used_r, out_used_nxt;
  logic                          out_empty_r, out_empty_nxt;

  logic [bfa_pkg::SIZE_W:0]      size_sum;
  logic [bfa_pkg::SIZE_W:0]      nodes_full;
  logic [bfa_pkg::CNT_W-1:0]     nodes_load;
  logic [bfa_pkg::ADDR_W-1:0]    offset;
  logic [bfa_pkg::CNT_W-1:0]     start_slot;
  logic [bfa_pkg::NUM_SLOTS:0]   ones_ext;
  logic                          bad_size;
  logic                          outside;
  logic [bfa_pkg::STATUS_W-1:0]  pre_status;
  logic [bfa_pkg::SLOT_W-1:0]    slot_idx;
  logic [bfa_pkg::CNT_W-1:0]     first;

  always_comb begin
    size_sum = {1'b0, in_size_bytes} + (bfa_pkg::SIZE_W + 1)'(bfa_pkg::NODE_BYTES - 1);
    nodes_full = (bfa_pkg::SIZE_W + 1)'(size_sum / bfa_pkg::NODE_BYTES);
    nodes_load = nodes_full[bfa_pkg::CNT_W-1:0];
    offset = in_address - pool_base_r;
    start_slot = bfa_pkg::CNT_W'(offset / bfa_pkg::NODE_BYTES);
    ones_ext = ((bfa_pkg::NUM_SLOTS + 1)'(1) << nodes_load) - (bfa_pkg::NUM_SLOTS + 1)'(1);
    bad_size = (in_size_bytes == '0) ||
               (nodes_full > (bfa_pkg::SIZE_W + 1)'(bfa_pkg::NUM_SLOTS));
    outside = (in_kind == bfa_pkg::KIND_RELEASE) && (offset >= bfa_pkg::POOL_BYTES);
    if (bad_size) begin
      pre_status = bfa_pkg::ST_BAD_SIZE;
    end else if (outside) begin
      pre_status = bfa_pkg::ST_OUTSIDE;
    end else begin
      pre_status = bfa_pkg::ST_OK;
    end
    slot_idx = slot_r[bfa_pkg::SLOT_W-1:0];
    first = slot_r - run_r;
  end

  always_comb begin
    pool_base_nxt = cfg_we ? cfg_wdata : pool_base_r;
    map_nxt = map_r;
    used_nxt = used_r;
    nodes_nxt = nodes_r;
    slot_nxt = slot_r;
    run_nxt = run_r;
    len_mask_nxt = len_mask_r;
    kind_nxt = kind_r;
    status_nxt = status_r;
    res_addr_nxt = res_addr_r;

    if (cmd.load) begin
      kind_nxt = in_kind;
      nodes_nxt = nodes_load;
      status_nxt = pre_status;
      res_addr_nxt = '0;
      len_mask_nxt = ones_ext[bfa_pkg::NUM_SLOTS-1:0];
      if (in_kind == bfa_pkg::KIND_RELEASE) begin
        slot_nxt = start_slot;
        run_nxt = nodes_load;
      end else begin
        slot_nxt = '0;
        run_nxt = '0;
      end
    end

    if (cmd.scan_step) begin
      run_nxt = map_r[slot_idx] ? '0 : run_r + bfa_pkg::CNT_W'(1);
      slot_nxt = slot_r + bfa_pkg::CNT_W'(1);
    end

    if (cmd.set_norun) begin
      status_nxt = bfa_pkg::ST_NO_RUN;
    end

    if (cmd.fill) begin
      map_nxt = map_r | (len_mask_r << first);
      used_nxt = used_r + nodes_r;
      res_addr_nxt = pool_base_r +
                     bfa_pkg::ADDR_W'(first) * bfa_pkg::ADDR_W'(bfa_pkg::NODE_BYTES);
    end

    if (cmd.clear_step) begin
      map_nxt[slot_idx] = 1'b0;
      if (map_r[slot_idx]) begin
        used_nxt = used_r - bfa_pkg::CNT_W'(1);
      end
      slot_nxt = slot_r + bfa_pkg::CNT_W'(1);
      run_nxt = run_r - bfa_pkg::CNT_W'(1);
    end

    out_status_nxt = out_status_r;
    out_addr_nxt = out_addr_r;
    out_used_nxt = out_used_r;
    out_empty_nxt = out_empty_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_status_nxt = status_r;
      out_addr_nxt = res_addr_r;
      out_used_nxt = bfa_pkg::USED_W'(used_r);
      out_empty_nxt = (used_r == '0);
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      map_r <= '0;
      used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pool_base_r <= pool_base_nxt;
      map_r <= map_nxt;
      used_r <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nodes_r <= nodes_nxt;
    slot_r <= slot_nxt;
    run_r <= run_nxt;
    len_mask_r <= len_mask_nxt;
    kind_r <= kind_nxt;
    status_r <= status_nxt;
    res_addr_r <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r <= out_addr_nxt;
    out_used_r <= out_used_nxt;
    out_empty_r <= out_empty_nxt;
  end

  always_comb begin
    stat.status = status_r;
    stat.kind = kind_r;
    stat.scan_found = (run_r == nodes_r);
    stat.scan_stop = (slot_r == bfa_pkg::CNT_W'(bfa_pkg::NUM_SLOTS)) || (run_r == nodes_r);
    stat.clear_stop = (run_r == '0) || (slot_r == bfa_pkg::CNT_W'(bfa_pkg::NUM_SLOTS));
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_address_res = out_addr_r;
  assign out_used_slots = out_used_r;
  assign out_pool_empty = out_empty_r;

endmodule

FILE: src/bitmap_first_fit_slot_allocator.sv
// Top level of the bitmap first-fit slot allocator: controller, datapath and channels.
//
// Requests arrive on in_ch as valid/ready transactions carrying kind (0 allocate,
// 1 release), a byte size and, for a release, the run's start address. Each
// request yields exactly one transaction on out_ch with a status, the allocated
// address, the used-slot count and an empty flag. pool_base is written through
// cfg_we/cfg_wdata; it is the user who must write it only while the block is idle,
// which the block itself does not enforce. One request is processed at a time.
// A rejected request goes from the check state straight to the done state. An
// allocate walks the bitmap one slot per cycle until the first long enough free
// run is found; the whole run is then marked at once in the fill state. A release
// clears the run one slot per cycle.
// The result is held in an output register; the next request is accepted in the
// cycle after the current result is loaded. A new result waits while out_ch is
// stalled.
// Synchronous active-low reset frees every slot, clears pool_base and drops
// out_ch valid.
module bitmap_first_fit_slot_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfa_pkg::ADDR_W-1:0]  cfg_wdata,
  bfa_in_if.sink                      in_ch,
  bfa_out_if.source                   out_ch
);

  bfa_pkg::ctrl_cmd_t cmd;
  bfa_pkg::dp_stat_t  stat;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_ch.kind),
    .in_size_bytes   (in_ch.size_bytes),
    .in_address      (in_ch.address),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_address_res (out_ch.address_res),
    .out_used_slots  (out_ch.used_slots),
    .out_pool_empty  (out_ch.pool_empty)
  );

endmodule
